// File: rtl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// Shared widths, command and status codes, and the cell control bundle for
// the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
package ilid_pkg;

  localparam int CAPACITY = 64;

  localparam int CMD_W   = 3;
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 2;
  localparam int LEN_W   = 7;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET       = 3'd0,
    CMD_ADD_HEAD  = 3'd1,
    CMD_ADD_TAIL  = 3'd2,
    CMD_ADD_INDEX = 3'd3,
    CMD_DELETE    = 3'd4
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: rtl/ilid_in_if.sv
// ----------------------------------------------------------------------------
// ilid_in_if
// Command channel: valid/ready handshake with command, position and value.
// ----------------------------------------------------------------------------
interface ilid_in_if
  import ilid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, command, position, value, input ready);
  modport sink   (input valid, command, position, value, output ready);
endinterface

// File: rtl/ilid_out_if.sv
// ----------------------------------------------------------------------------
// ilid_out_if
// Result channel: valid/ready handshake with read value, status and length.
// ----------------------------------------------------------------------------
interface ilid_out_if
  import ilid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STAT_W-1:0]        status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, read_value, status, length, input ready);
  modport sink   (input valid, read_value, status, length, output ready);
endinterface

// File: rtl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// One list slot: holds an entry, takes the new value, its left neighbor's
// entry on insert or its right neighbor's entry on delete.
// ----------------------------------------------------------------------------
module ilid_cell
  import ilid_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cell_ctl_t         ctl,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    if (ctl.ins) begin
      if (idx == ctl.pos) begin
        data_nxt = ctl.value;
      end else if (idx > ctl.pos) begin
        data_nxt = left_data;
      end
    end else if (ctl.del && (idx >= ctl.pos)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  // masked so the row can be or-reduced for a read
  assign rd_data = (idx == ctl.pos) ? data_r : '0;

endmodule

// File: rtl/indexed_list_insert_delete_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Bounded ordered list of signed 32-bit entries held in a row of cells, with
// get, insert at head/tail/index and delete at index.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  in_ch     in    valid / ready    command, position, value
//  out_ch    out   valid / ready    read_value, status, length
//
// one command per cycle when not stalled: the result is registered in the
// cycle after the transfer, and all cells shift together on insert or delete.
// in_ch.ready is high when the output register is empty or being drained.
// a stalled result holds the output register and blocks new commands only.
// reset (synchronous, active low) empties the list; entry contents are kept.
module indexed_list_insert_delete_unit
  import ilid_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  ilid_in_if.sink    in_ch,
  ilid_out_if.source out_ch
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic [DATA_W-1:0] rd_val_r;
  logic [DATA_W-1:0] rd_val_nxt;
  logic [STAT_W-1:0] status_r;
  logic [STAT_W-1:0] status_nxt;

  logic              xfer;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic [CMP_W-1:0]  ins_pos_c;
  logic              is_ins;
  logic              do_ins;
  logic              do_del;
  logic [DATA_W-1:0] rd_or;
  cell_ctl_t         ctl;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign xfer        = in_ch.valid && in_ch.ready;

  assign pos_c = CMP_W'(in_ch.position);
  assign cnt_c = CMP_W'(count_r);

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    rd_val_nxt = '0;
    status_nxt = ST_DONE;
    is_ins     = 1'b0;
    do_del     = 1'b0;
    ins_pos_c  = pos_c;
    case (in_ch.command)
      CMD_GET: begin
        if (pos_c < cnt_c) begin
          rd_val_nxt = rd_or;
        end else begin
          rd_val_nxt = '1;
          status_nxt = ST_RANGE;
        end
      end
      CMD_ADD_HEAD: begin
        is_ins    = 1'b1;
        ins_pos_c = '0;
      end
      CMD_ADD_TAIL: begin
        is_ins    = 1'b1;
        ins_pos_c = cnt_c;
      end
      CMD_ADD_INDEX: begin
        is_ins = 1'b1;
      end
      CMD_DELETE: begin
        if (pos_c < cnt_c) begin
          do_del = 1'b1;
        end else begin
          status_nxt = ST_RANGE;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
    do_ins = 1'b0;
    if (is_ins) begin
      // range check wins over the full check
      if (ins_pos_c > cnt_c) begin
        status_nxt = ST_RANGE;
      end else if (count_r == CNT_W'(CAPACITY)) begin
        status_nxt = ST_FULL;
      end else begin
        do_ins = 1'b1;
      end
    end
  end

  always_comb begin
    ctl.ins   = xfer && do_ins;
    ctl.del   = xfer && do_del;
    ctl.pos   = is_ins ? IDX_W'(ins_pos_c) : IDX_W'(pos_c);
    ctl.value = in_ch.value;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (g == 0) begin : g_first
      assign left_d = in_ch.value;
    end else begin : g_mid_l
      assign left_d = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[g];
    end else begin : g_mid_r
      assign right_d = cell_data[g+1];
    end
    ilid_cell u_cell (
      .clk        (clk),
      .idx        (IDX_W'(g)),
      .ctl        (ctl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[g]),
      .rd_data    (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      rd_val_r <= rd_val_nxt;
      status_r <= status_nxt;
    end
  end

  logic [LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (xfer) begin
      len_r <= LEN_W'(count_nxt);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = rd_val_r;
  assign out_ch.status     = status_r;
  assign out_ch.length     = len_r;

endmodule
